// ===== rtl/hsv_to_argb_pixel_assert.svh =====
// assertion macros for the hsv to argb pixel converter
`ifndef HSV_TO_ARGB_PIXEL_ASSERT_SVH
`define HSV_TO_ARGB_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define HSV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_argb_pixel: same-cycle check failed");
// next-cycle implication, disabled in reset
`define HSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_argb_pixel: next-cycle check failed");
`else
`define HSV_ASSERT_IMPL(label, ante, cons)
`define HSV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/hsv2argb_pkg.sv =====
// shared types and constants for the hsv to argb pixel converter
package hsv2argb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [2:0] sector_t;

    // hue sectors of 60 degrees each
    localparam sector_t SECTOR_RED_YELLOW   = 3'd0;
    localparam sector_t SECTOR_YELLOW_GREEN = 3'd1;
    localparam sector_t SECTOR_GREEN_CYAN   = 3'd2;
    localparam sector_t SECTOR_CYAN_BLUE    = 3'd3;
    localparam sector_t SECTOR_BLUE_MAGENTA = 3'd4;

endpackage

// ===== rtl/hsv_to_argb_pixel.sv =====
// hsv to argb pixel converter, three-stage pipeline
//
// Usage:
//   Input channel carries hue, saturation and brightness as unsigned fractions
//   with FRAC_BITS fraction bits (1 << FRAC_BITS stands for 1.0); a beat is
//   taken at a rising edge with in_valid high and in_stall low. Values above
//   1.0 are clamped to 1.0.
//   Output channel carries one 32-bit argb_word per input beat, alpha 0xFF,
//   red 23:16, green 15:8, blue 7:0; taken with out_valid high, out_stall low.
//   Throughput: one pixel per clock while out_stall is low. Stage one
//   holds the s*v multiplier, stage two the chroma times (1-d) multiplier,
//   stage three the channel select, offset add and byte saturation into
//   the output register.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When out_stall is high the output beat holds; the stages behind it keep
//   filling bubbles, and in_stall rises only once every stage is occupied.
`include "hsv_to_argb_pixel_assert.svh"

module hsv_to_argb_pixel
    import hsv2argb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FRAC_BITS:0]   hue,
    input  logic [FRAC_BITS:0]   saturation,
    input  logic [FRAC_BITS:0]   brightness,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          argb_word
);

    localparam int F1 = FRAC_BITS + 1;
    localparam logic [F1-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [7:0] to_byte(input logic [F1:0] val);
        logic [7:0] res;
        if (val >= {1'b0, ONE})
        begin
            res = 8'hFF;
        end
        else
        begin
            res = val[FRAC_BITS-1 -: 8];
        end
        return res;
    endfunction

    // stage enables, back to front
    logic en1, en2, en3;

    logic            s1_valid_reg;
    logic [F1-1:0]   s1_c_reg;
    logic [F1-1:0]   s1_v_reg;
    logic [F1-1:0]   s1_omd_reg;
    sector_t         s1_sector_reg;

    logic            s2_valid_reg;
    logic [F1-1:0]   s2_c_reg;
    logic [F1-1:0]   s2_x_reg;
    logic [F1-1:0]   s2_m_reg;
    sector_t         s2_sector_reg;

    logic            out_valid_reg;
    logic [31:0]     argb_reg;

    assign en3      = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    // stage 1: clamp, chroma, sector and distance from the nearest odd sector boundary
    logic [F1-1:0]        h_c, s_c, v_c;
    logic [2*F1-1:0]      prod_sv;
    logic [FRAC_BITS+2:0] hp;
    logic [F1-1:0]        f_pos;
    logic [F1-1:0]        d_dist;
    logic [F1-1:0]        s1_c_next;
    logic [F1-1:0]        s1_omd_next;
    sector_t              s1_sector_next;

    always_comb
    begin
        h_c = (hue > ONE) ? ONE : hue;
        s_c = (saturation > ONE) ? ONE : saturation;
        v_c = (brightness > ONE) ? ONE : brightness;
        prod_sv = {{F1{1'b0}}, s_c} * {{F1{1'b0}}, v_c};
        s1_c_next = prod_sv[FRAC_BITS +: F1];
        // h*6 as (h<<2) + (h<<1)
        hp = ({2'b00, h_c} << 2) + ({2'b00, h_c} << 1);
        s1_sector_next = hp[FRAC_BITS+2:FRAC_BITS];
        f_pos = hp[FRAC_BITS:0];
        d_dist = (f_pos >= ONE) ? (f_pos - ONE) : (ONE - f_pos);
        s1_omd_next = ONE - d_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_c_reg      <= s1_c_next;
            s1_v_reg      <= v_c;
            s1_omd_reg    <= s1_omd_next;
            s1_sector_reg <= s1_sector_next;
        end
    end

    // stage 2: second component and offset
    logic [2*F1-1:0] prod_x;
    logic [F1-1:0]   s2_x_next;
    logic [F1-1:0]   s2_m_next;

    always_comb
    begin
        prod_x    = {{F1{1'b0}}, s1_c_reg} * {{F1{1'b0}}, s1_omd_reg};
        s2_x_next = prod_x[FRAC_BITS +: F1];
        s2_m_next = s1_v_reg - s1_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_c_reg      <= s1_c_reg;
            s2_x_reg      <= s2_x_next;
            s2_m_reg      <= s2_m_next;
            s2_sector_reg <= s1_sector_reg;
        end
    end

    // stage 3: place chroma by sector, add offset, saturate to bytes
    logic [F1-1:0] ch_r, ch_g, ch_b;
    logic [F1:0]   sum_r, sum_g, sum_b;
    logic [31:0]   argb_next;

    always_comb
    begin
        ch_r = '0;
        ch_g = '0;
        ch_b = '0;
        case (s2_sector_reg)
            SECTOR_RED_YELLOW:
            begin
                ch_r = s2_c_reg;
                ch_g = s2_x_reg;
            end
            SECTOR_YELLOW_GREEN:
            begin
                ch_r = s2_x_reg;
                ch_g = s2_c_reg;
            end
            SECTOR_GREEN_CYAN:
            begin
                ch_g = s2_c_reg;
                ch_b = s2_x_reg;
            end
            SECTOR_CYAN_BLUE:
            begin
                ch_g = s2_x_reg;
                ch_b = s2_c_reg;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                ch_r = s2_x_reg;
                ch_b = s2_c_reg;
            end
            // last sector, also hue of exactly one turn
            default:
            begin
                ch_r = s2_c_reg;
                ch_b = s2_x_reg;
            end
        endcase
        sum_r = {1'b0, ch_r} + {1'b0, s2_m_reg};
        sum_g = {1'b0, ch_g} + {1'b0, s2_m_reg};
        sum_b = {1'b0, ch_b} + {1'b0, s2_m_reg};
        argb_next = {ALPHA_OPAQUE, to_byte(sum_r), to_byte(sum_g), to_byte(sum_b)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            argb_reg <= argb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign argb_word = argb_reg;

    // a blocked first stage keeps its beat
    `HSV_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !en2, s1_valid_reg && $stable(s1_c_reg))
    // the second component never exceeds chroma
    `HSV_ASSERT_IMPL(a_x_le_c, s2_valid_reg, s2_x_reg <= s2_c_reg)
    // chroma plus offset is the clamped value, never above one
    `HSV_ASSERT_IMPL(a_cm_le_one, s2_valid_reg, ({1'b0, s2_m_reg} + {1'b0, s2_c_reg}) <= {1'b0, ONE})
    // a beat moving out of stage two lands in the output register
    `HSV_ASSERT_NEXT(a_s2_to_out, s2_valid_reg && en3, out_valid_reg)

endmodule

// ===== tb/sv/hsv_to_argb_pixel_checker.sv =====
// argb word predictor and comparator that watches both channels of the converter
module hsv_to_argb_pixel_checker
    import hsv2argb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [FRAC_BITS_DEF:0]   hue,
    input  logic [FRAC_BITS_DEF:0]   saturation,
    input  logic [FRAC_BITS_DEF:0]   brightness,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [31:0]              argb_word,
    output int                       mismatch_count,
    output int                       words_pending,
    output int                       words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS_DEF;

    logic [31:0] argb_expected[$];

    function automatic logic [7:0] channel_byte(input logic [63:0] level);
        if (level >= UNIT)
            return 8'hFF;
        return 8'((level >> (FRAC_BITS_DEF - 8)) & 64'hFF);
    endfunction

    function automatic logic [63:0] clamp_unit(input logic [FRAC_BITS_DEF:0] frac);
        return (64'(frac) > UNIT) ? UNIT : 64'(frac);
    endfunction

    function automatic logic [31:0] hsv_to_argb(input logic [FRAC_BITS_DEF:0] h_in,
                                                 input logic [FRAC_BITS_DEF:0] s_in,
                                                 input logic [FRAC_BITS_DEF:0] v_in);
        logic [63:0] h, s, v, chroma, hpos, frac2, center_dist, second, offset;
        logic [63:0] red, green, blue;
        sector_t     sector;
        h      = clamp_unit(h_in);
        s      = clamp_unit(s_in);
        v      = clamp_unit(v_in);
        chroma = (s * v) >> FRAC_BITS_DEF;
        hpos   = h * 6;
        sector = sector_t'(hpos >> FRAC_BITS_DEF);
        frac2  = hpos % (2 * UNIT);
        center_dist = (frac2 >= UNIT) ? (frac2 - UNIT) : (UNIT - frac2);
        second = (chroma * (UNIT - center_dist)) >> FRAC_BITS_DEF;
        offset = v - chroma;
        red    = '0;
        green  = '0;
        blue   = '0;
        case (sector)
            SECTOR_RED_YELLOW:   begin red = chroma;   green = second; end
            SECTOR_YELLOW_GREEN: begin red = second;   green = chroma; end
            SECTOR_GREEN_CYAN:   begin green = chroma; blue = second;  end
            SECTOR_CYAN_BLUE:    begin green = second; blue = chroma;  end
            SECTOR_BLUE_MAGENTA: begin red = second;   blue = chroma;  end
            // last sector, also taken by a hue of exactly one
            default:             begin red = chroma;   blue = second;  end
        endcase
        return {ALPHA_OPAQUE, channel_byte(red + offset), channel_byte(green + offset),
                channel_byte(blue + offset)};
    endfunction

    initial
    begin
        mismatch_count = 0;
        words_pending  = 0;
        words_checked  = 0;
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                argb_expected.push_back(hsv_to_argb(hue, saturation, brightness));
            if (out_valid && !out_stall)
            begin
                if (argb_expected.size() == 0)
                begin
                    $display("%0t unexpected argb_word %08h with no pixel outstanding",
                             $time, argb_word);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = argb_expected.pop_front();
                    words_checked <= words_checked + 1;
                    if (argb_word !== want)
                    begin
                        $display("%0t argb_word mismatch: expected %08h actual %08h",
                                 $time, want, argb_word);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            words_pending <= argb_expected.size();
        end
    end

endmodule

// ===== tb/sv/hsv_to_argb_pixel_tb.sv =====
// top of the hsv to argb converter bench: clock, reset, pixel and back-pressure stimulus
module hsv_to_argb_pixel_tb;
    import hsv2argb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT         = 1 << FRAC_BITS_DEF;
    localparam int FIELD_MAX    = (1 << (FRAC_BITS_DEF + 1)) - 1;
    localparam int RANDOM_BEATS = 1330;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [FRAC_BITS_DEF:0] hue = '0;
    logic [FRAC_BITS_DEF:0] saturation = '0;
    logic [FRAC_BITS_DEF:0] brightness = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [31:0]            argb_word;

    int mismatch_count;
    int words_pending;
    int words_checked;
    int pixels_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit holding_off = 1'b0;

    hsv_to_argb_pixel DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .argb_word  (argb_word)
    );

    hsv_to_argb_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hue            (hue),
        .saturation     (saturation),
        .brightness     (brightness),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .argb_word      (argb_word),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly back-to-back, some short gaps, a few long ones, and gap-free bursts
    function automatic int sender_gap();
        int pick;
        if (holding_off)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [FRAC_BITS_DEF:0] rand_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return (FRAC_BITS_DEF + 1)'(UNIT);
            2:       return (FRAC_BITS_DEF + 1)'($urandom_range(UNIT + 1, FIELD_MAX));
            3:       return (FRAC_BITS_DEF + 1)'($urandom_range(UNIT - 16, UNIT));
            default: return (FRAC_BITS_DEF + 1)'($urandom_range(0, UNIT));
        endcase
    endfunction

    // a third of hues land within a few lsb of a sector boundary
    function automatic logic [FRAC_BITS_DEF:0] rand_hue();
        int boundary;
        if ($urandom_range(0, 2) != 0)
            return rand_fraction();
        boundary = ($urandom_range(1, 5) * UNIT + 5) / 6;
        return (FRAC_BITS_DEF + 1)'(boundary + $urandom_range(0, 4) - 2);
    endfunction

    task automatic send_pixel(input int h, input int s, input int v);
        int gap;
        hue        <= (FRAC_BITS_DEF + 1)'(h);
        saturation <= (FRAC_BITS_DEF + 1)'(s);
        brightness <= (FRAC_BITS_DEF + 1)'(v);
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // no beat on either channel for too long means the block is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d words outstanding",
                         idle_cycles, words_pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int free_len;
        int stall_len;
        int segment;
        segment = 0;
        @(posedge rst_n);
        forever
        begin
            free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (free_len) @(posedge clk);
            segment++;
            if (segment % 300 == 25)
            begin
                // long hold-off so the pipeline fills and pushes back on the input
                holding_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding_off = 1'b0;
            end
            else
            begin
                stall_len = $urandom_range(0, 99);
                if (stall_len < 70)
                    stall_len = 0;
                else if (stall_len < 95)
                    stall_len = $urandom_range(1, 4);
                else
                    stall_len = $urandom_range(10, 30);
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        @(posedge rst_n);
        @(posedge clk);

        send_pixel(0, 0, 0);
        send_pixel(UNIT, UNIT, UNIT);
        send_pixel(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_pixel(UNIT + 1, 0, UNIT);
        send_pixel(0, UNIT, UNIT);
        send_pixel(10922, UNIT, UNIT);
        send_pixel(10923, UNIT, UNIT);
        send_pixel(21846, UNIT, UNIT);
        send_pixel(32767, UNIT, UNIT);
        send_pixel(32768, UNIT, UNIT);
        send_pixel(43691, UNIT, UNIT);
        send_pixel(54613, UNIT, UNIT);
        send_pixel(54614, UNIT, UNIT);
        send_pixel(UNIT - 1, UNIT, UNIT);
        send_pixel(0, 0, UNIT);
        send_pixel(0, UNIT, 0);
        send_pixel(16384, 32768, 49152);
        send_pixel(0, FIELD_MAX, UNIT);
        send_pixel(49152, UNIT, FIELD_MAX);
        send_pixel(1, 1, 1);
        send_pixel(UNIT, 0, 32768);

        repeat (RANDOM_BEATS)
            send_pixel(rand_hue(), rand_fraction(), rand_fraction());
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixels, %0d argb words compared: sector edges, clamped fields,",
                 pixels_sent, words_checked);
        $display("hue of one, saturated channels, random gaps and a long output hold-off");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
